/* src/raycol_pkg.sv */
// shared types and constants for the raycast column pixel shader
// no dependencies
`default_nettype none
package raycol_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int HEIGHT_W = 11;
    localparam int RGB_W = 24;
    localparam int TEXQ_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEST_TEX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORTH_TEX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EAST_TEX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUTH_TEX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING_RGB   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_RGB     = 3'd6;

    localparam logic [1:0] REGION_CEILING = 2'd0;
    localparam logic [1:0] REGION_WALL    = 2'd1;
    localparam logic [1:0] REGION_FLOOR   = 2'd2;

    typedef struct packed {
        logic [HEIGHT_W-1:0]            screen_height;
        logic [3:0][HEIGHT_W-1:0]       tex_height;
        logic [RGB_W-1:0]               ceiling_rgb;
        logic [RGB_W-1:0]               floor_rgb;
    } cfg_t;

endpackage
`default_nettype wire

/* src/raycol_div.sv */
// pipelined restoring divider, one quotient bit per stage, with side payload
// no package dependency
`default_nettype none
module raycol_div #(
    parameter int DW  = 16,
    parameter int QW  = 19,
    parameter int PLW = 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [DW-1:0]  in_rem,
    input  wire logic [QW-1:0]  in_bits,
    input  wire logic [DW-1:0]  in_den,
    input  wire logic [PLW-1:0] in_data,
    output logic                out_valid,
    output logic [QW-1:0]       out_quot,
    output logic [PLW-1:0]      out_data
);
    logic           v_reg    [QW];
    logic [DW-1:0]  rem_reg  [QW];
    logic [QW-1:0]  bits_reg [QW];
    logic [QW-1:0]  quot_reg [QW];
    logic [DW-1:0]  den_reg  [QW];
    logic [PLW-1:0] data_reg [QW];

    logic           p_v    [QW+1];
    logic [DW-1:0]  p_rem  [QW+1];
    logic [QW-1:0]  p_bits [QW+1];
    logic [QW-1:0]  p_quot [QW+1];
    logic [DW-1:0]  p_den  [QW+1];
    logic [PLW-1:0] p_data [QW+1];

    assign p_v[0]    = in_valid;
    assign p_rem[0]  = in_rem;
    assign p_bits[0] = in_bits;
    assign p_quot[0] = '0;
    assign p_den[0]  = in_den;
    assign p_data[0] = in_data;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;

        assign p_v[k+1]    = v_reg[k];
        assign p_rem[k+1]  = rem_reg[k];
        assign p_bits[k+1] = bits_reg[k];
        assign p_quot[k+1] = quot_reg[k];
        assign p_den[k+1]  = den_reg[k];
        assign p_data[k+1] = data_reg[k];

        assign trial    = {p_rem[k], p_bits[k][QW-1]};
        assign ge       = trial >= {1'b0, p_den[k]};
        assign rem_next = ge ? DW'(trial - {1'b0, p_den[k]}) : DW'(trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= p_v[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                bits_reg[k] <= p_bits[k] << 1;
                quot_reg[k] <= {p_quot[k][QW-2:0], ge};
                den_reg[k]  <= p_den[k];
                data_reg[k] <= p_data[k];
            end
        end
    end

    assign out_valid = p_v[QW];
    assign out_quot  = p_quot[QW];
    assign out_data  = p_data[QW];

endmodule
`default_nettype wire

/* src/raycol_front.sv */
// front end: wall height division, span classification and texel row product
// depends on raycol_pkg and raycol_div
`default_nettype none
module raycol_front #(
    parameter int MAX_SCREEN_HEIGHT  = 1024,
    parameter int DIST_FRACTION_BITS = 8,
    parameter int HW = $clog2(MAX_SCREEN_HEIGHT + 1),
    parameter int SW = HW + DIST_FRACTION_BITS,
    parameter int PW = SW + 11
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire raycol_pkg::cfg_t    cfg,
    input  wire logic                in_valid,
    input  wire logic [11:0]         in_column,
    input  wire logic [9:0]          in_row,
    input  wire logic [15:0]         in_dist,
    input  wire logic [1:0]          in_side,
    input  wire logic [9:0]          in_tx,
    output logic                     out_valid,
    output logic [11:0]              out_column,
    output logic [9:0]               out_row,
    output logic [1:0]               out_region,
    output logic [1:0]               out_side,
    output logic [9:0]               out_tx,
    output logic [SW-1:0]            out_wh,
    output logic [PW-1:0]            out_product
);
    import raycol_pkg::*;

    localparam int CW  = (HW > HEIGHT_W) ? HW : HEIGHT_W;
    localparam int XW  = SW + 2;
    localparam int PLW = 34 + HW;

    logic [CW-1:0]  sh_w;
    logic [HW-1:0]  h_in;
    logic [15:0]    den;
    logic           d_valid;
    logic [SW-1:0]  d_quot;
    logic [PLW-1:0] d_data;

    assign sh_w = CW'(cfg.screen_height);
    assign h_in = (sh_w > CW'(MAX_SCREEN_HEIGHT)) ? HW'(MAX_SCREEN_HEIGHT) : HW'(sh_w);
    // zero distance gives the same height as a distance of one lsb
    assign den  = (in_dist == 16'd0) ? 16'd1 : in_dist;

    raycol_div #(.DW(16), .QW(SW), .PLW(PLW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (1'b1),
        .in_valid (in_valid),
        .in_rem   (16'd0),
        .in_bits  ({h_in, {DIST_FRACTION_BITS{1'b0}}}),
        .in_den   (den),
        .in_data  ({in_column, in_row, in_side, in_tx, h_in}),
        .out_valid(d_valid),
        .out_quot (d_quot),
        .out_data (d_data)
    );

    logic [11:0]          d_column;
    logic [9:0]           d_row;
    logic [1:0]           d_side;
    logic [9:0]           d_tx;
    logic [HW-1:0]        d_h;
    logic [HW-1:0]        hh;
    logic [SW-1:0]        wq;
    logic signed [XW-1:0] top_raw;
    logic [XW-1:0]        bot_sum;
    logic [XW-1:0]        bottom;
    logic [XW-1:0]        row_x;
    logic [XW-1:0]        offset_x;
    logic [1:0]           region_next;

    assign {d_column, d_row, d_side, d_tx, d_h} = d_data;
    assign hh       = d_h >> 1;
    assign wq       = d_quot >> 1;
    assign top_raw  = $signed(XW'(hh)) - $signed(XW'(wq));
    assign bot_sum  = XW'(hh) + XW'(wq);
    assign bottom   = (bot_sum > XW'(d_h)) ? XW'(d_h) : bot_sum;
    assign row_x    = XW'(d_row);
    assign offset_x = row_x - XW'(top_raw);

    always_comb begin
        if ($signed(row_x) < top_raw) begin
            region_next = REGION_CEILING;
        end else if (row_x < bottom) begin
            region_next = REGION_WALL;
        end else begin
            region_next = REGION_FLOOR;
        end
    end

    // classification stage
    logic                c1_valid_reg;
    logic [11:0]         c1_column_reg;
    logic [9:0]          c1_row_reg;
    logic [1:0]          c1_region_reg;
    logic [1:0]          c1_side_reg;
    logic [9:0]          c1_tx_reg;
    logic [SW-1:0]       c1_wh_reg;
    logic [SW-1:0]       c1_offset_reg;
    logic [HEIGHT_W-1:0] c1_th_reg;

    // product stage
    logic                c2_valid_reg;
    logic [11:0]         c2_column_reg;
    logic [9:0]          c2_row_reg;
    logic [1:0]          c2_region_reg;
    logic [1:0]          c2_side_reg;
    logic [9:0]          c2_tx_reg;
    logic [SW-1:0]       c2_wh_reg;
    logic [PW-1:0]       c2_product_reg;
    logic [PW-1:0]       product_next;

    assign product_next = PW'(c1_offset_reg) * PW'(c1_th_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end else begin
            c1_valid_reg <= d_valid;
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        c1_column_reg  <= d_column;
        c1_row_reg     <= d_row;
        c1_region_reg  <= region_next;
        c1_side_reg    <= d_side;
        c1_tx_reg      <= d_tx;
        c1_wh_reg      <= d_quot;
        c1_offset_reg  <= SW'(offset_x);
        c1_th_reg      <= cfg.tex_height[d_side];
        c2_column_reg  <= c1_column_reg;
        c2_row_reg     <= c1_row_reg;
        c2_region_reg  <= c1_region_reg;
        c2_side_reg    <= c1_side_reg;
        c2_tx_reg      <= c1_tx_reg;
        c2_wh_reg      <= c1_wh_reg;
        c2_product_reg <= product_next;
    end

    assign out_valid   = c2_valid_reg;
    assign out_column  = c2_column_reg;
    assign out_row     = c2_row_reg;
    assign out_region  = c2_region_reg;
    assign out_side    = c2_side_reg;
    assign out_tx      = c2_tx_reg;
    assign out_wh      = c2_wh_reg;
    assign out_product = c2_product_reg;

endmodule
`default_nettype wire

/* src/raycol_queue.sv */
// small fifo between the front and back ends
// no package dependency
`default_nettype none
module raycol_queue #(
    parameter int DW    = 64,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_data,
    input  wire logic          pop,
    output logic               not_empty,
    output logic [DW-1:0]      pop_data,
    output logic [AW:0]        count
);
    logic [DW-1:0] mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= AW'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= AW'(rd_ptr_reg + 1'b1);
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule
`default_nettype wire

/* src/raycol_back.sv */
// back end: texel row division and result formatting with a stallable pipeline
// depends on raycol_pkg and raycol_div
`default_nettype none
module raycol_back #(
    parameter int MAX_TEXTURE_SIZE = 1024,
    parameter int SW = 19,
    parameter int PW = SW + 11
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire raycol_pkg::cfg_t cfg,
    input  wire logic             q_valid,
    output logic                  q_pop,
    input  wire logic [11:0]      q_column,
    input  wire logic [9:0]       q_row,
    input  wire logic [1:0]       q_region,
    input  wire logic [1:0]       q_side,
    input  wire logic [9:0]       q_tx,
    input  wire logic [SW-1:0]    q_wh,
    input  wire logic [PW-1:0]    q_product,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [71:0]           out_data
);
    import raycol_pkg::*;

    localparam int PLW = 36;

    logic           en;
    logic           d_valid;
    logic [TEXQ_W-1:0] d_quot;
    logic [PLW-1:0] d_data;
    logic           out_valid_reg;
    logic [71:0]    out_data_reg;

    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && q_valid;

    raycol_div #(.DW(SW), .QW(TEXQ_W), .PLW(PLW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (q_valid),
        .in_rem   (q_product[PW-1:TEXQ_W]),
        .in_bits  (q_product[TEXQ_W-1:0]),
        .in_den   (q_wh),
        .in_data  ({q_column, q_row, q_region, q_side, q_tx}),
        .out_valid(d_valid),
        .out_quot (d_quot),
        .out_data (d_data)
    );

    logic [11:0] d_column;
    logic [9:0]  d_row;
    logic [1:0]  d_region;
    logic [1:0]  d_side;
    logic [9:0]  d_tx;
    logic [9:0]  tex_y;
    logic [RGB_W-1:0] rgb;
    logic [1:0]  o_side;
    logic [9:0]  o_x;
    logic [9:0]  o_y;

    assign {d_column, d_row, d_region, d_side, d_tx} = d_data;
    assign tex_y = (32'(d_quot) > 32'(MAX_TEXTURE_SIZE - 1))
                 ? 10'(MAX_TEXTURE_SIZE - 1) : d_quot[9:0];

    always_comb begin
        rgb    = '0;
        o_side = 2'd0;
        o_x    = 10'd0;
        o_y    = 10'd0;
        case (d_region)
            REGION_CEILING: rgb = cfg.ceiling_rgb;
            REGION_WALL: begin
                o_side = d_side;
                o_x    = d_tx;
                o_y    = tex_y;
            end
            default: rgb = cfg.floor_rgb;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {2'b0, o_y, o_x, o_side, rgb, d_region, d_row, d_column};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

/* src/raycast_column_pixel_shader_core.sv */
// top level of the raycast column pixel shader: config registers, front, queue, back
// depends on raycol_pkg, raycol_front, raycol_queue and raycol_back
//
// channel   dir  handshake            payload
// s_axis    in   s_tvalid / s_tready  column, row, wall_distance, wall_side, texture_x
// m_axis    out  m_tvalid / m_tready  pixel fields, region, colour, texel coordinates
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one pixel per clock sustained while m_tready is high; a pixel passes the wall height
// divider (one stage per quotient bit, HW + DIST_FRACTION_BITS), the classification and
// product stages, the queue, the texel row divider (eleven stages) and output register
// reset is synchronous on aresetn low and loads the default register values
// a stalled output freezes the back pipeline; the front runs freely and s_tready
// drops once front items in flight plus queued items would fill the queue
`default_nettype none
module raycast_column_pixel_shader_core #(
    parameter int MAX_SCREEN_HEIGHT  = 1024,
    parameter int MAX_TEXTURE_SIZE   = 1024,
    parameter int DIST_FRACTION_BITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // column[11:0], row[21:12], wall_distance[37:22], wall_side[39:38], texture_x[49:40]
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel_column[11:0], pixel_row[21:12], region[23:22], flat_rgb[47:24],
    // texel_side[49:48], texel_x[59:50], texel_y[69:60]
    output logic [71:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [raycol_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [raycol_pkg::CFG_DATA_W-1:0] cfg_data
);
    import raycol_pkg::*;

    localparam int HW    = $clog2(MAX_SCREEN_HEIGHT + 1);
    localparam int SW    = HW + DIST_FRACTION_BITS;
    localparam int PW    = SW + TEXQ_W;
    localparam int QD    = 2 ** $clog2(SW + 6);
    localparam int QAW   = $clog2(QD);
    localparam int QDW   = 36 + SW + PW;
    localparam int CNTW  = QAW + 2;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_height <= HEIGHT_W'(480);
            cfg_reg.tex_height    <= {4{HEIGHT_W'(64)}};
            cfg_reg.ceiling_rgb   <= RGB_W'(24'h4664E1);
            cfg_reg.floor_rgb     <= RGB_W'(24'hC89614);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[HEIGHT_W-1:0];
                CFG_WEST_TEX:      cfg_reg.tex_height[0] <= cfg_data[HEIGHT_W-1:0];
                CFG_NORTH_TEX:     cfg_reg.tex_height[1] <= cfg_data[HEIGHT_W-1:0];
                CFG_EAST_TEX:      cfg_reg.tex_height[2] <= cfg_data[HEIGHT_W-1:0];
                CFG_SOUTH_TEX:     cfg_reg.tex_height[3] <= cfg_data[HEIGHT_W-1:0];
                CFG_CEILING_RGB:   cfg_reg.ceiling_rgb   <= cfg_data[RGB_W-1:0];
                CFG_FLOOR_RGB:     cfg_reg.floor_rgb     <= cfg_data[RGB_W-1:0];
                default: ;
            endcase
        end
    end

    logic            in_acc;
    logic            f_valid;
    logic [11:0]     f_column;
    logic [9:0]      f_row;
    logic [1:0]      f_region;
    logic [1:0]      f_side;
    logic [9:0]      f_tx;
    logic [SW-1:0]   f_wh;
    logic [PW-1:0]   f_product;
    logic            q_valid;
    logic            q_pop;
    logic [QDW-1:0]  q_data;
    logic [QAW:0]    q_count;
    logic [CNTW-1:0] inflight_reg;

    assign in_acc   = s_tvalid && s_tready;
    // credit check so the free-running front never overruns the queue
    assign s_tready = (CNTW'(inflight_reg) + CNTW'(q_count)) < CNTW'(QD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_reg + CNTW'(in_acc) - CNTW'(f_valid);
        end
    end

    raycol_front #(
        .MAX_SCREEN_HEIGHT (MAX_SCREEN_HEIGHT),
        .DIST_FRACTION_BITS(DIST_FRACTION_BITS),
        .HW(HW), .SW(SW), .PW(PW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (in_acc),
        .in_column  (s_tdata[11:0]),
        .in_row     (s_tdata[21:12]),
        .in_dist    (s_tdata[37:22]),
        .in_side    (s_tdata[39:38]),
        .in_tx      (s_tdata[49:40]),
        .out_valid  (f_valid),
        .out_column (f_column),
        .out_row    (f_row),
        .out_region (f_region),
        .out_side   (f_side),
        .out_tx     (f_tx),
        .out_wh     (f_wh),
        .out_product(f_product)
    );

    raycol_queue #(.DW(QDW), .DEPTH(QD)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (f_valid),
        .push_data({f_column, f_row, f_region, f_side, f_tx, f_wh, f_product}),
        .pop      (q_pop),
        .not_empty(q_valid),
        .pop_data (q_data),
        .count    (q_count)
    );

    raycol_back #(.MAX_TEXTURE_SIZE(MAX_TEXTURE_SIZE), .SW(SW), .PW(PW)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_column (q_data[QDW-1 -: 12]),
        .q_row    (q_data[QDW-13 -: 10]),
        .q_region (q_data[QDW-23 -: 2]),
        .q_side   (q_data[QDW-25 -: 2]),
        .q_tx     (q_data[QDW-27 -: 10]),
        .q_wh     (q_data[PW +: SW]),
        .q_product(q_data[PW-1:0]),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata)
    );

endmodule
`default_nettype wire

/* src/raycol_checker.sv */
// port-level checks for the raycast column pixel shader, bound to the top level
// no package dependency
`default_nettype none
module raycol_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata
);
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_region_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:22] != 2'd3)
        else $error("region code out of range");

    a_wall_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[23:22] == 2'd1 |-> m_tdata[47:24] == 24'd0)
        else $error("wall pixel carries a flat colour");

    a_flat_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[23:22] != 2'd1 |-> m_tdata[69:48] == 22'd0)
        else $error("flat pixel carries texel fields");

endmodule

bind raycast_column_pixel_shader_core raycol_checker u_raycol_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
`default_nettype wire
